@@ src/baro_pressure_temp_compensation_assert.svh @@
// Assertion macros for the barometric compensation block.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define BPTC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bptc_pkg.sv @@
// Shared types, widths and constants of the barometric compensation block.
// No dependencies; imported by every other file but the assertion macro header.
package bptc_pkg;

	localparam int RAW_W  = 24;
	localparam int COEF_W = 16;
	localparam int IDX_W  = 3;
	localparam int DT_W   = 25;
	localparam int TEMP_W = 19;
	localparam int PRES_W = 32;
	localparam int WIDE_W = 40;
	localparam int T2_W   = 18;
	localparam int SQ_W   = 40;

	localparam int TEMP_REF = 2000;
	localparam int TEMP_LOW = -1500;
	localparam int TEMP_MIN = -262144;
	localparam int TEMP_MAX = 262143;

	typedef logic [RAW_W-1:0]         raw_t;
	typedef logic [COEF_W-1:0]        coef_t;
	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic signed [PRES_W-1:0] pres_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SENS     = 3'd0,
		REG_OFF      = 3'd1,
		REG_SENS_TC  = 3'd2,
		REG_OFF_TC   = 3'd3,
		REG_TREF     = 3'd4,
		REG_TEMPSENS = 3'd5
	} reg_idx_t;

	typedef struct packed {
		coef_t sens;
		coef_t off;
		coef_t sens_tc;
		coef_t off_tc;
		coef_t tref;
		coef_t tempsens;
	} coef_set_t;

	// first-order terms
	typedef struct packed {
		raw_t              d1;
		temp_t             temp;
		logic [T2_W-1:0]   t2;
		wide_t             off;
		wide_t             sens;
	} fo_t;

	// terms after second-order correction
	typedef struct packed {
		raw_t  d1;
		temp_t temp;
		wide_t off;
		wide_t sens;
	} so_t;

endpackage

@@ src/bptc_sample_if.sv @@
// Input channel: one raw pressure / temperature pair per transaction.
// Depends on bptc_pkg.
interface bptc_sample_if import bptc_pkg::*; ();
	logic valid;
	logic ready;
	raw_t raw_pressure;
	raw_t raw_temperature;

	modport source(output valid, raw_pressure, raw_temperature, input ready);
	modport sink(input valid, raw_pressure, raw_temperature, output ready);
endinterface

@@ src/bptc_result_if.sv @@
// Output channel: compensated temperature and pressure per transaction.
// Depends on bptc_pkg.
interface bptc_result_if import bptc_pkg::*; ();
	logic  valid;
	logic  ready;
	temp_t temperature_centi;
	pres_t pressure_comp;

	modport source(output valid, temperature_centi, pressure_comp, input ready);
	modport sink(input valid, temperature_centi, pressure_comp, output ready);
endinterface

@@ src/baro_pressure_temp_compensation.sv @@
// Barometric pressure / temperature compensation, second order, top level.
// Depends on bptc_pkg, the channel interfaces, bptc_cfg_regs, bptc_first_order,
// bptc_second_order, bptc_pressure and the assertion macro header.
//
// Usage:
//  - Load the six calibration words through cfg_write/cfg_index/cfg_data
//    while no transaction is in flight; indexes six and seven are ignored.
//  - Each sample transaction carries one raw pressure / temperature pair and
//    gives exactly one result transaction, in order: temperature in
//    0.01 degC and pressure in 0.01 mbar.
//  - Ten register stages, each with its own valid bit. Throughput is one
//    transaction per cycle while the receiver keeps result.ready high; the
//    stage count is set by the multiplier stages (dT products, deviation
//    squares, D1*SENS split into two partial products) with an adder stage
//    between each.
//  - A stage advances whenever it is empty or the stage after it advances,
//    so bubbles close up; sample.ready only falls when all ten stages are
//    full and the receiver holds result.ready low. Nothing is dropped or
//    repeated under stall.
//  - Reset clears the valid bits and the calibration words to zero.
`include "baro_pressure_temp_compensation_assert.svh"

module baro_pressure_temp_compensation import bptc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [IDX_W-1:0] cfg_index,
	input  coef_t            cfg_data,
	bptc_sample_if.sink      sample,
	bptc_result_if.source    result
);

	coef_set_t coef;
	logic      fo_valid, fo_ready;
	fo_t       fo_data;
	logic      so_valid, so_ready;
	so_t       so_data;

	bptc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	bptc_first_order u_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.sample    (sample),
		.out_valid (fo_valid),
		.out_ready (fo_ready),
		.out_data  (fo_data)
	);

	bptc_second_order u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fo_valid),
		.in_ready  (fo_ready),
		.in_data   (fo_data),
		.out_valid (so_valid),
		.out_ready (so_ready),
		.out_data  (so_data)
	);

	bptc_pressure u_pres (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (so_valid),
		.in_ready (so_ready),
		.in_data  (so_data),
		.result   (result)
	);

	`BPTC_ASSERT_IMPL(a_ready_if_drained, result.ready, sample.ready, "input refused while output drains")
	`BPTC_ASSERT_IMPL(a_ready_if_empty, !result.valid, sample.ready, "input refused with empty output")
	`BPTC_ASSERT_NEXT(a_refuse_means_stall, !sample.ready, result.valid, "input refused without held result")

endmodule

@@ src/bptc_cfg_regs.sv @@
// Calibration word registers behind the plain write port.
// Depends on bptc_pkg.
module bptc_cfg_regs import bptc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [IDX_W-1:0] cfg_index,
	input  coef_t            cfg_data,
	output coef_set_t        coef
);

	coef_set_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SENS:     coef_q.sens     <= cfg_data;
				REG_OFF:      coef_q.off      <= cfg_data;
				REG_SENS_TC:  coef_q.sens_tc  <= cfg_data;
				REG_OFF_TC:   coef_q.off_tc   <= cfg_data;
				REG_TREF:     coef_q.tref     <= cfg_data;
				REG_TEMPSENS: coef_q.tempsens <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

@@ src/bptc_first_order.sv @@
// Stages 1-3: dT, the four dT products, first-order TEMP, OFF, SENS and T2.
// Depends on bptc_pkg and bptc_sample_if.
module bptc_first_order import bptc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  coef_set_t     coef,
	bptc_sample_if.sink   sample,
	output logic          out_valid,
	input  logic          out_ready,
	output fo_t           out_data
);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	raw_t                   d1_s1, d1_s2;
	logic signed [DT_W-1:0] dt_s1;
	logic signed [41:0]     p6_s2, p4_s2, p3_s2;
	logic signed [49:0]     pdd_s2;
	fo_t                    fo_s3;

	logic signed [DT_W-1:0] dt_n;
	logic                   fix6, fix4, fix3;
	logic signed [19:0]     temp_n;
	wide_t                  off_n, sens_n;

	assign rdy_s3 = !v_s3 || out_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign sample.ready = rdy_s1;

	assign dt_n = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, coef.tref, 8'h00});

	// truncation toward zero: add one to the floor when negative and inexact
	assign fix6 = p6_s2[41] & (|p6_s2[22:0]);
	assign fix4 = p4_s2[41] & (|p4_s2[6:0]);
	assign fix3 = p3_s2[41] & (|p3_s2[7:0]);

	assign temp_n = 20'(TEMP_REF) + {p6_s2[41], p6_s2[41:23]} + {19'd0, fix6};
	assign off_n  = {8'h00, coef.off, 16'h0000} + {{5{p4_s2[41]}}, p4_s2[41:7]}
		+ {39'd0, fix4};
	assign sens_n = {9'd0, coef.sens, 15'd0} + {{6{p3_s2[41]}}, p3_s2[41:8]}
		+ {39'd0, fix3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= sample.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && sample.valid) begin
			d1_s1 <= sample.raw_pressure;
			dt_s1 <= dt_n;
		end
		if (rdy_s2 && v_s1) begin
			d1_s2  <= d1_s1;
			p6_s2  <= dt_s1 * $signed({1'b0, coef.tempsens});
			p4_s2  <= dt_s1 * $signed({1'b0, coef.off_tc});
			p3_s2  <= dt_s1 * $signed({1'b0, coef.sens_tc});
			pdd_s2 <= dt_s1 * dt_s1;
		end
		if (rdy_s3 && v_s2) begin
			fo_s3.d1   <= d1_s2;
			fo_s3.temp <= temp_n[TEMP_W-1:0];
			fo_s3.t2   <= pdd_s2[48:31];
			fo_s3.off  <= off_n;
			fo_s3.sens <= sens_n;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = fo_s3;

endmodule

@@ src/bptc_second_order.sv @@
// Stages 4-6: squares of the temperature deviation, OFF2/SENS2/T2, and their
// subtraction. Depends on bptc_pkg.
module bptc_second_order import bptc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  fo_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output so_t  out_data
);

	logic v_s4, v_s5, v_s6;
	logic rdy_s4, rdy_s5, rdy_s6;

	fo_t             fo_s4, fo_s5;
	logic [SQ_W-1:0] sq_a_s4, sq_b_s4;
	logic            lt_ref_s4, lt_low_s4;
	logic [WIDE_W-1:0] off2_s5, sens2_s5;
	logic [T2_W-1:0]   t2_s5;
	so_t             so_s6;

	logic signed [19:0] dev_ref, dev_low;
	logic signed [SQ_W-1:0] sq_a_n, sq_b_n;
	logic [41:0] five_a;
	logic [42:0] seven_b, eleven_b, off2_n, sens2_n;
	logic signed [19:0] temp_c;
	temp_t temp_sat;

	assign rdy_s6 = !v_s6 || out_ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	assign dev_ref = 20'(in_data.temp) - 20'(TEMP_REF);
	assign dev_low = 20'(in_data.temp) - 20'(TEMP_LOW);
	assign sq_a_n  = dev_ref * dev_ref;
	assign sq_b_n  = dev_low * dev_low;

	assign five_a   = {sq_a_s4, 2'b00} + {2'b00, sq_a_s4};
	assign seven_b  = {sq_b_s4, 3'b000} - {3'b000, sq_b_s4};
	assign eleven_b = {sq_b_s4, 3'b000} + {2'b00, sq_b_s4, 1'b0} + {3'b000, sq_b_s4};

	always_comb begin
		off2_n  = {2'b00, five_a[41:1]};
		sens2_n = {3'b000, five_a[41:2]};
		if (lt_low_s4) begin
			off2_n  = off2_n + seven_b;
			sens2_n = sens2_n + {1'b0, eleven_b[42:1]};
		end
		if (!lt_ref_s4) begin
			off2_n  = '0;
			sens2_n = '0;
		end
	end

	assign temp_c = 20'(fo_s5.temp) - $signed({2'b00, t2_s5});

	always_comb begin
		if (temp_c > 20'(TEMP_MAX)) begin
			temp_sat = TEMP_W'(TEMP_MAX);
		end else if (temp_c < 20'(TEMP_MIN)) begin
			temp_sat = TEMP_W'(TEMP_MIN);
		end else begin
			temp_sat = temp_c[TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= in_valid;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			fo_s4     <= in_data;
			sq_a_s4   <= sq_a_n;
			sq_b_s4   <= sq_b_n;
			lt_ref_s4 <= in_data.temp < TEMP_W'(TEMP_REF);
			lt_low_s4 <= in_data.temp < TEMP_W'(TEMP_LOW);
		end
		if (rdy_s5 && v_s4) begin
			fo_s5    <= fo_s4;
			off2_s5  <= off2_n[WIDE_W-1:0];
			sens2_s5 <= sens2_n[WIDE_W-1:0];
			t2_s5    <= lt_ref_s4 ? fo_s4.t2 : '0;
		end
		if (rdy_s6 && v_s5) begin
			so_s6.d1   <= fo_s5.d1;
			so_s6.temp <= temp_sat;
			so_s6.off  <= fo_s5.off - off2_s5;
			so_s6.sens <= fo_s5.sens - sens2_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = so_s6;

endmodule

@@ src/bptc_pressure.sv @@
// Stages 7-10: D1*SENS as two partial products, /2^21, minus OFF, /2^15,
// output register. Depends on bptc_pkg and bptc_result_if.
module bptc_pressure import bptc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  so_t           in_data,
	bptc_result_if.source result
);

	logic v_s7, v_s8, v_s9, v_s10;
	logic rdy_s7, rdy_s8, rdy_s9, rdy_s10;

	temp_t              temp_s7, temp_s8, temp_s9, temp_s10;
	wide_t              off_s7, off_s8;
	logic [44:0]        plo_s7;
	logic signed [43:0] phi_s7;
	logic signed [43:0] qf_s8;
	logic               nz_s8;
	logic signed [44:0] x_s9;
	pres_t              pres_s10;

	logic signed [43:0] qf_n;
	logic               fix_q, fix_p;
	logic signed [44:0] x_n;
	logic signed [30:0] y_n;

	assign rdy_s10 = !v_s10 || result.ready;
	assign rdy_s9  = !v_s9 || rdy_s10;
	assign rdy_s8  = !v_s8 || rdy_s9;
	assign rdy_s7  = !v_s7 || rdy_s8;
	assign in_ready = rdy_s7;

	// floor(D1*SENS / 2^21) from the high and low partial products
	assign qf_n  = phi_s7 + $signed({20'd0, plo_s7[44:21]});
	assign fix_q = qf_s8[43] & nz_s8;
	assign x_n   = 45'(qf_s8) - 45'(off_s8) + $signed({44'd0, fix_q});
	assign fix_p = x_s9[44] & (|x_s9[14:0]);
	assign y_n   = $signed({x_s9[44], x_s9[44:15]}) + $signed({30'd0, fix_p});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (rdy_s7)  v_s7  <= in_valid;
			if (rdy_s8)  v_s8  <= v_s7;
			if (rdy_s9)  v_s9  <= v_s8;
			if (rdy_s10) v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7 && in_valid) begin
			temp_s7 <= in_data.temp;
			off_s7  <= in_data.off;
			plo_s7  <= in_data.d1 * in_data.sens[20:0];
			phi_s7  <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens[WIDE_W-1:21]);
		end
		if (rdy_s8 && v_s7) begin
			temp_s8 <= temp_s7;
			off_s8  <= off_s7;
			qf_s8   <= qf_n;
			nz_s8   <= |plo_s7[20:0];
		end
		if (rdy_s9 && v_s8) begin
			temp_s9 <= temp_s8;
			x_s9    <= x_n;
		end
		if (rdy_s10 && v_s9) begin
			temp_s10 <= temp_s9;
			// a 31-bit quotient always lies inside the 32-bit range
			pres_s10 <= PRES_W'(y_n);
		end
	end

	assign result.valid             = v_s10;
	assign result.temperature_centi = temp_s10;
	assign result.pressure_comp     = pres_s10;

endmodule

@@ bench/tb_baro_pressure_temp_compensation.sv @@
`timescale 1ns / 100ps
// Self-checking bench for baro_pressure_temp_compensation: random and directed
// reading pairs under several calibration sets, checked against an integer predictor.
// Depends on bptc_pkg, bptc_sample_if, bptc_result_if and the block under test.
module tb_baro_pressure_temp_compensation;
	import bptc_pkg::*;

	localparam int LATENCY        = 9;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int IDLE_PCT       = 26;
	localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;
	localparam raw_t RAW_MAX      = 24'hFFFFFF;

	typedef struct {
		temp_t temp;
		pres_t pres;
	} reading_t;

	class bptc_scoreboard;
		coef_set_t coefs;
		reading_t  expected_q[$];
		int        errors;

		function new();
			coefs = '0;
			errors = 0;
		endfunction

		function void set_coef(logic [IDX_W-1:0] idx, coef_t v);
			case (idx)
				REG_SENS:     coefs.sens = v;
				REG_OFF:      coefs.off = v;
				REG_SENS_TC:  coefs.sens_tc = v;
				REG_OFF_TC:   coefs.off_tc = v;
				REG_TREF:     coefs.tref = v;
				REG_TEMPSENS: coefs.tempsens = v;
				default: ;
			endcase
		endfunction

		function reading_t compensate(raw_t d1_raw, raw_t d2_raw);
			longint c_sens, c_off, c_sens_tc, c_off_tc, c_tref, c_tempsens;
			longint d1, dt, temp, off, sens, t2, off2, sens2, sq, p;
			reading_t r;
			c_sens = coefs.sens;
			c_off = coefs.off;
			c_sens_tc = coefs.sens_tc;
			c_off_tc = coefs.off_tc;
			c_tref = coefs.tref;
			c_tempsens = coefs.tempsens;
			d1 = d1_raw;
			dt = d2_raw;
			dt = dt - c_tref * 256;
			temp = TEMP_REF + (dt * c_tempsens) / 8388608;
			off = c_off * 65536 + (c_off_tc * dt) / 128;
			sens = c_sens * 32768 + (c_sens_tc * dt) / 256;
			t2 = 0;
			off2 = 0;
			sens2 = 0;
			if (temp < TEMP_REF) begin
				t2 = (dt * dt) / 64'sd2147483648;
				sq = (temp - TEMP_REF) * (temp - TEMP_REF);
				off2 = (5 * sq) / 2;
				sens2 = (5 * sq) / 4;
				if (temp < TEMP_LOW) begin
					sq = (temp - TEMP_LOW) * (temp - TEMP_LOW);
					off2 = off2 + 7 * sq;
					sens2 = sens2 + (11 * sq) / 2;
				end
			end
			temp = temp - t2;
			off = off - off2;
			sens = sens - sens2;
			p = ((d1 * sens) / 2097152 - off) / 32768;
			if (p < -64'sd2147483648)
				p = -64'sd2147483648;
			else if (p > 64'sd2147483647)
				p = 64'sd2147483647;
			if (temp < TEMP_MIN)
				temp = TEMP_MIN;
			else if (temp > TEMP_MAX)
				temp = TEMP_MAX;
			r.temp = temp_t'(temp);
			r.pres = pres_t'(p);
			return r;
		endfunction

		function void note_sample(raw_t p, raw_t t);
			expected_q.push_back(compensate(p, t));
		endfunction

		function void check_result(temp_t t, pres_t p);
			reading_t e;
			if (expected_q.size() == 0) begin
				$error("result transaction with no reading expected: temp %0d, pressure %0d",
					t, p);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (t !== e.temp) begin
				$error("temperature_centi: expected %0d, actual %0d", e.temp, t);
				errors++;
			end
			if (p !== e.pres) begin
				$error("pressure_comp: expected %0d, actual %0d", e.pres, p);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_write;
	logic [IDX_W-1:0] cfg_index;
	coef_t            cfg_data;
	bit               steady;

	bptc_sample_if sample_ch();
	bptc_result_if result_ch();

	bptc_scoreboard readings = new();

	baro_pressure_temp_compensation i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit idle_roll();
		return !steady && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	function automatic raw_t rand_raw_temp(coef_t tref);
		int centre;
		if ($urandom_range(0, 1))
			return raw_t'($urandom);
		centre = int'(tref) * 256 + $urandom_range(0, 2 ** 21) - 2 ** 20;
		if (centre < 0)
			centre = 0;
		else if (centre > int'(RAW_MAX))
			centre = int'(RAW_MAX);
		return raw_t'(centre);
	endfunction

	task automatic send_sample(raw_t p, raw_t t);
		while (idle_roll()) begin
			sample_ch.valid <= 1'b0;
			sample_ch.raw_pressure <= raw_t'($urandom);
			sample_ch.raw_temperature <= raw_t'($urandom);
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.raw_pressure <= p;
		sample_ch.raw_temperature <= t;
		do @(posedge clk); while (!sample_ch.ready);
		readings.note_sample(p, t);
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (readings.pending() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_one(logic [IDX_W-1:0] idx, coef_t v);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		readings.set_coef(idx, v);
	endtask

	task automatic load_coefs(coef_set_t c, bit spare);
		write_one(REG_SENS, c.sens);
		write_one(REG_OFF, c.off);
		write_one(REG_SENS_TC, c.sens_tc);
		write_one(REG_OFF_TC, c.off_tc);
		write_one(REG_TREF, c.tref);
		write_one(REG_TEMPSENS, c.tempsens);
		if (spare) begin
			write_one(IDX_SPARE_LO, coef_t'($urandom));
			write_one(IDX_SPARE_HI, coef_t'($urandom));
		end
		cfg_write <= 1'b0;
	endtask

	task automatic send_corners();
		send_sample('0, '0);
		send_sample(RAW_MAX, RAW_MAX);
		send_sample('0, RAW_MAX);
		send_sample(RAW_MAX, '0);
	endtask

	task automatic run_random(int n);
		repeat (n)
			send_sample(raw_t'($urandom), rand_raw_temp(readings.coefs.tref));
	endtask

	function automatic coef_set_t rand_coefs();
		coef_set_t c;
		c.sens = coef_t'($urandom);
		c.off = coef_t'($urandom);
		c.sens_tc = coef_t'($urandom);
		c.off_tc = coef_t'($urandom);
		c.tref = coef_t'($urandom);
		c.tempsens = coef_t'($urandom);
		return c;
	endfunction

	// receiver side
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready)
				readings.check_result(result_ch.temperature_centi, result_ch.pressure_comp);
			result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		coef_set_t c;
		steady = 1'b0;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.raw_pressure <= '0;
		sample_ch.raw_temperature <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// calibration words still at reset
		send_corners();
		run_random(150);
		wait_drained();

		// typical factory calibration
		c.sens = 16'd40127;
		c.off = 16'd36924;
		c.sens_tc = 16'd23317;
		c.off_tc = 16'd23282;
		c.tref = 16'd33464;
		c.tempsens = 16'd28312;
		load_coefs(c, 1'b0);
		send_sample(24'd9085466, 24'd8569150);
		send_sample(24'd9085466, 24'd8566784);   // dT zero, exactly 20 degC
		send_sample(24'd9085466, 24'd8566783);   // small negative dT truncates to 20 degC
		send_sample(24'd9085466, 24'd8566487);   // just below 20 degC
		send_sample(24'd9085466, 24'd7466784);   // below -15 degC
		send_sample(24'd9085466, '0);
		send_sample('0, RAW_MAX);
		send_sample(RAW_MAX, RAW_MAX);
		send_sample(RAW_MAX, '0);
		run_random(100);
		wait_drained();
		steady = 1'b1;
		run_random(150);
		steady = 1'b0;
		run_random(100);
		wait_drained();

		// all words at maximum, spare indexes written too
		c = '1;
		load_coefs(c, 1'b1);
		send_corners();
		run_random(150);
		wait_drained();

		// only the temperature terms active
		c = '0;
		c.sens_tc = '1;
		c.off_tc = '1;
		c.tempsens = '1;
		load_coefs(c, 1'b1);
		send_corners();
		run_random(150);
		wait_drained();

		repeat (3) begin
			load_coefs(rand_coefs(), 1'b0);
			run_random(150);
			wait_drained();
		end

		repeat (2 * LATENCY) @(posedge clk);
		if (readings.errors == 0 && readings.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
